[hdl/mr_pkg.sv]
`default_nettype none

package mr_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODULUS     = 2'd0;
    localparam cfg_index_t REG_NEG_INVERSE = 2'd1;
    localparam cfg_index_t REG_R_SQUARED   = 2'd2;

    localparam int CFG_DATA_W = 32;
    localparam int VALUE_W    = 64;
    localparam int RESULT_W   = 33;

    // operation codes
    localparam logic OP_REDUCE    = 1'b0;
    localparam logic OP_TRANSFORM = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET     = 32'h0000_0001;
    localparam logic [CFG_DATA_W-1:0] NEG_INVERSE_RESET = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] R_SQUARED_RESET   = 32'h0000_0000;

endpackage

`default_nettype wire

[hdl/montgomery_reduction_32.sv]
// a transaction accepted at the input passes the cell 0, 1, 2 and 3 registers in order before its result is valid
// throughput: one transaction per cycle while the output is not stalled, a chain of four registered cells
// (transform multiply, quotient multiply, modulus multiply, add and subtract)
// a stalled output fills the chain before the input stalls
// reset: asynchronous active low, clears all cell valids and loads the
// configuration registers with modulus 1, neg_inverse all ones, r_squared 0
`default_nettype none

module montgomery_reduction_32
    import mr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    operation,
    input  wire logic [VALUE_W-1:0]      value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [RESULT_W-1:0]          result
);

    logic [CFG_DATA_W-1:0]  modulus_reg;
    logic [CFG_DATA_W-1:0]  neg_inverse_reg;
    logic [CFG_DATA_W-1:0]  r_squared_reg;

    logic                   v0;
    logic                   v1;
    logic                   v2;
    logic                   s1;
    logic                   s2;
    logic                   s3;
    logic [2*WIDTH-1:0]     product0;
    logic [2*WIDTH-1:0]     product1;
    logic [2*WIDTH-1:0]     product2;
    logic [2*WIDTH:0]       pass0;
    logic [2*WIDTH-1:0]     pass1;
    logic [2*WIDTH-1:0]     pass2;
    logic [2*WIDTH-1:0]     t1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= MODULUS_RESET;
            neg_inverse_reg <= NEG_INVERSE_RESET;
            r_squared_reg   <= R_SQUARED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODULUS:     modulus_reg     <= cfg_data;
                REG_NEG_INVERSE: neg_inverse_reg <= cfg_data;
                REG_R_SQUARED:   r_squared_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // cell 0: operand times r_squared, used only by transform
    mr_mul_cell #(
        .WIDTH  (WIDTH),
        .PASS_W (2*WIDTH+1)
    ) u_cell0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a         (value[WIDTH-1:0]),
        .b         (r_squared_reg[WIDTH-1:0]),
        .pass_in   ({operation, value[2*WIDTH-1:0]}),
        .out_valid (v0),
        .out_stall (s1),
        .product   (product0),
        .pass_out  (pass0)
    );

    assign t1 = (pass0[2*WIDTH] == OP_TRANSFORM) ? product0 : pass0[2*WIDTH-1:0];

    // cell 1: m = t * neg_inverse mod R
    mr_mul_cell #(
        .WIDTH  (WIDTH),
        .PASS_W (2*WIDTH)
    ) u_cell1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0),
        .in_stall  (s1),
        .a         (t1[WIDTH-1:0]),
        .b         (neg_inverse_reg[WIDTH-1:0]),
        .pass_in   (t1),
        .out_valid (v1),
        .out_stall (s2),
        .product   (product1),
        .pass_out  (pass1)
    );

    // cell 2: m * modulus
    mr_mul_cell #(
        .WIDTH  (WIDTH),
        .PASS_W (2*WIDTH)
    ) u_cell2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_stall  (s2),
        .a         (product1[WIDTH-1:0]),
        .b         (modulus_reg[WIDTH-1:0]),
        .pass_in   (pass1),
        .out_valid (v2),
        .out_stall (s3),
        .product   (product2),
        .pass_out  (pass2)
    );

    // cell 3: (t + m*p) / R and one conditional subtraction
    mr_final_cell #(
        .WIDTH (WIDTH)
    ) u_cell3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_stall  (s3),
        .t         (pass2),
        .mp        (product2),
        .modulus   (modulus_reg[WIDTH-1:0]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

`ifndef SYNTHESIS
    // the input only stalls when every cell holds a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v0 && v1 && v2 && out_valid))
        else $error("input stalled with an empty cell");

    // an accepted transaction lands in the first cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v0)
        else $error("accepted transaction lost at first cell");

    // the quotient never exceeds WIDTH+1 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result >> (WIDTH + 1)) == '0))
        else $error("result wider than WIDTH+1 bits");
`endif

endmodule

`default_nettype wire

[hdl/mr_mul_cell.sv]
`default_nettype none

module mr_mul_cell
    import mr_pkg::*;
#(
    parameter int WIDTH  = 32,
    parameter int PASS_W = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [WIDTH-1:0]     a,
    input  wire logic [WIDTH-1:0]     b,
    input  wire logic [PASS_W-1:0]    pass_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2*WIDTH-1:0]        product,
    output logic [PASS_W-1:0]         pass_out
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [2*WIDTH-1:0]    product_reg;
    logic [2*WIDTH-1:0]    product_next;
    logic [PASS_W-1:0]     pass_reg;
    logic                  advance;

    // the cell moves when it is empty or its neighbor takes its contents
    assign advance      = !valid_reg || !out_stall;
    assign in_stall     = !advance;
    assign valid_next   = advance ? in_valid : valid_reg;
    assign product_next = (2*WIDTH)'(a) * (2*WIDTH)'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            product_reg <= product_next;
            pass_reg    <= pass_in;
        end
    end

    assign out_valid = valid_reg;
    assign product   = product_reg;
    assign pass_out  = pass_reg;

endmodule

`default_nettype wire

[hdl/mr_final_cell.sv]
`default_nettype none

module mr_final_cell
    import mr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2*WIDTH-1:0]   t,
    input  wire logic [2*WIDTH-1:0]   mp,
    input  wire logic [WIDTH-1:0]     modulus,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [RESULT_W-1:0]       result
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [RESULT_W-1:0]   result_reg;
    logic [RESULT_W-1:0]   result_next;
    logic                  advance;
    logic [WIDTH:0]        sum_lo;
    logic [WIDTH:0]        q;
    logic [WIDTH:0]        p_ext;
    logic [WIDTH:0]        q_sub;

    assign advance    = !valid_reg || !out_stall;
    assign in_stall   = !advance;
    assign valid_next = advance ? in_valid : valid_reg;

    // low half only contributes its carry, the low bits are zero by construction
    assign sum_lo = {1'b0, t[WIDTH-1:0]} + {1'b0, mp[WIDTH-1:0]};
    assign q      = {1'b0, t[2*WIDTH-1:WIDTH]} + {1'b0, mp[2*WIDTH-1:WIDTH]}
                    + (WIDTH+1)'(sum_lo[WIDTH]);
    assign p_ext  = {1'b0, modulus};
    assign q_sub  = (q >= p_ext) ? (q - p_ext) : q;
    assign result_next = RESULT_W'(q_sub);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

[sim/montgomery_reduction_32_checker.sv]
`timescale 1ns / 1ps

module montgomery_reduction_32_checker
    import mr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic                    operation,
    input  wire logic [VALUE_W-1:0]      value,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic [RESULT_W-1:0]     result,
    output int                           mismatches,
    output int                           outstanding
);

    logic [CFG_DATA_W-1:0] modulus_q;
    logic [CFG_DATA_W-1:0] neg_inverse_q;
    logic [CFG_DATA_W-1:0] r_squared_q;
    logic [RESULT_W-1:0]   expected_results [$];
    logic [RESULT_W-1:0]   wanted;
    logic [VALUE_W-1:0]    product;

    // REDC with one conditional subtraction, sum formed exactly in 34 bits
    function automatic logic [RESULT_W-1:0] montgomery_reduce(
        input logic [63:0] t,
        input logic [31:0] p,
        input logic [31:0] ni
    );
        logic [31:0] m;
        logic [63:0] mp;
        logic [32:0] low_sum;
        logic [33:0] q;
        m       = 32'(64'(t[31:0]) * 64'(ni));
        mp      = 64'(m) * 64'(p);
        low_sum = {1'b0, t[31:0]} + {1'b0, mp[31:0]};
        q       = 34'(t[63:32]) + 34'(mp[63:32]) + 34'(low_sum[32]);
        if (q >= 34'(p))
            q = q - 34'(p);
        return q[RESULT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q     = MODULUS_RESET;
            neg_inverse_q = NEG_INVERSE_RESET;
            r_squared_q   = R_SQUARED_RESET;
            expected_results.delete();
            outstanding   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == OP_TRANSFORM)
                    product = 64'(value[31:0]) * 64'(r_squared_q);
                else
                    product = value;
                expected_results.push_back(
                    montgomery_reduce(product, modulus_q, neg_inverse_q));
            end

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result %h arrived with no transaction waiting", result);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (result !== wanted)
                    begin
                        $error("result: expected %h, actual %h", wanted, result);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:     modulus_q     = cfg_data;
                    REG_NEG_INVERSE: neg_inverse_q = cfg_data;
                    REG_R_SQUARED:   r_squared_q   = cfg_data;
                    default:         ;
                endcase
            end

            outstanding = expected_results.size();
        end
    end

endmodule

[sim/montgomery_reduction_32_test.sv]
`timescale 1ns / 1ps

module montgomery_reduction_32_test
    import mr_pkg::*;
();

    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 190;
    localparam int         SETTLE_CYCLES   = 8;
    localparam cfg_index_t REG_UNUSED      = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_index_t              cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    operation;
    logic [VALUE_W-1:0]      value;
    logic                    out_valid;
    logic                    out_stall;
    logic [RESULT_W-1:0]     result;

    int mismatches;
    int outstanding;
    int sender_idle_pct = 14;
    int receiver_idle_pct = 51;

    always #1 clk = ~clk;

    montgomery_reduction_32 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    montgomery_reduction_32_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // -P^-1 mod 2^32 by Newton iteration, seed is good to 3 bits for odd p
    function automatic logic [31:0] neg_inverse_of(input logic [31:0] p);
        logic [31:0] x;
        x = p;
        repeat (4)
            x = x * (32'd2 - p * x);
        return -x;
    endfunction

    function automatic logic [31:0] r_squared_of(input logic [31:0] p);
        logic [64:0] r;
        r = 65'd1 << 64;
        return 32'(r % 65'(p));
    endfunction

    function automatic logic [VALUE_W-1:0] random_value(input logic op, input logic [31:0] p);
        int          pick;
        logic [31:0] part;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            case ($urandom_range(4))
                0:       return '0;
                1:       return '1;
                2:       return {p - 32'd1, 32'hFFFF_FFFF};
                3:       return {p, 32'h0};
                default: return 64'(p);
            endcase
        end
        else if (pick < 30)
            return {$urandom, $urandom};
        part = (p == 0) ? $urandom : $urandom % p;
        if (op == OP_REDUCE)
            return {part, 32'($urandom)};
        return {32'($urandom), part};
    endfunction

    task automatic send_item(input logic op, input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_block(input logic [31:0] p, input logic [31:0] ni,
                                 input logic [31:0] r2);
        write_register(REG_MODULUS, p);
        write_register(REG_NEG_INVERSE, ni);
        write_register(REG_R_SQUARED, r2);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver side
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    initial
    begin
        logic [31:0]        mod_tab [PHASES];
        logic [31:0]        ni_tab [PHASES];
        logic [31:0]        r2_tab [PHASES];
        logic [VALUE_W-1:0] corners [$];
        logic [31:0]        p;
        logic               op;

        cfg_valid <= 1'b0;
        cfg_index <= REG_MODULUS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        operation <= OP_REDUCE;
        value     <= '0;

        mod_tab[0] = 32'hFFFF_FFFF;
        mod_tab[1] = 32'd1;
        mod_tab[2] = 32'd3;
        mod_tab[3] = $urandom | 32'h8000_0001;
        mod_tab[4] = $urandom_range(65535, 3) | 32'd1;
        mod_tab[7] = $urandom | 32'd1;
        foreach (mod_tab[i])
        begin
            ni_tab[i] = neg_inverse_of(mod_tab[i]);
            r2_tab[i] = r_squared_of(mod_tab[i]);
        end
        // deliberately inconsistent settings: even modulus, then zero modulus
        mod_tab[5] = ($urandom & 32'hFFFF_FFFE) | 32'h0001_0000;
        ni_tab[5]  = 32'h0;
        r2_tab[5]  = 32'hFFFF_FFFF;
        mod_tab[6] = 32'h0;
        ni_tab[6]  = $urandom;
        r2_tab[6]  = $urandom;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration
        send_item(OP_REDUCE, '1);
        send_item(OP_TRANSFORM, '1);
        drain_results();

        // corner values with the largest modulus
        p = mod_tab[0];
        program_block(p, ni_tab[0], r2_tab[0]);
        corners = '{64'h0, '1, {p - 32'd1, 32'hFFFF_FFFF}, {p, 32'h0},
                    64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h1};
        foreach (corners[i])
            send_item(OP_REDUCE, corners[i]);
        corners = '{64'h0, 64'h1, 64'(p), 64'(p - 32'd1), '1,
                    64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA};
        foreach (corners[i])
            send_item(OP_TRANSFORM, corners[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase == 3)
            begin
                sender_idle_pct   = 51;
                receiver_idle_pct = 14;
            end
            else if (phase == 6)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (phase == 5)
                write_register(REG_UNUSED, $urandom);
            program_block(mod_tab[phase], ni_tab[phase], r2_tab[phase]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 3 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                op = $urandom_range(1) ? OP_TRANSFORM : OP_REDUCE;
                send_item(op, random_value(op, mod_tab[phase]));
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("montgomery_reduction_32_test passed");
        else
            $display("montgomery_reduction_32_test failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("montgomery_reduction_32_test failed");
        $finish;
    end

endmodule
